// File: hw/rtl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg: shared types and constants of the separable Gaussian blur engine
// Command and status types between controller and datapath, register
// indexes, reset values and the channel arithmetic helpers.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_RADIUS_DEF = 4;

  localparam int COORD_W     = 6;
  localparam int DIM_W       = 7;
  localparam int RADIUS_W    = 3;
  localparam int WEIGHT_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int PIXEL_W     = 32;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int TAP_SHIFT   = 16;
  localparam int NUM_WEIGHTS = 5;
  localparam int PROD_W      = CH_W + WEIGHT_W;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_W_CENTER = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_W_ONE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_W_TWO    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_W_THREE  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_W_FOUR   = 3'd7;

  localparam logic [DIM_W-1:0]    WIDTH_RST    = 7'd64;
  localparam logic [DIM_W-1:0]    HEIGHT_RST   = 7'd64;
  localparam logic [RADIUS_W-1:0] RADIUS_RST   = 3'd2;
  localparam logic [WEIGHT_W-1:0] W_CENTER_RST = 16'd16475;
  localparam logic [WEIGHT_W-1:0] W_ONE_RST    = 16'd14541;
  localparam logic [WEIGHT_W-1:0] W_TWO_RST    = 16'd9992;
  localparam logic [WEIGHT_W-1:0] W_THREE_RST  = 16'd0;
  localparam logic [WEIGHT_W-1:0] W_FOUR_RST   = 16'd0;

  // transaction opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [3:0] off_t;

  typedef struct packed {
    logic capture;   // query accepted: latch coordinate, clear vertical sum
    logic wr_en;     // write accepted inside the image
    logic rd_en;     // issue one frame read at the given offsets
    off_t kh;
    off_t kv;
    logic first_h;
    logic last_h;
    logic last_v;
    logic load_out;  // move the result into the output register
  } sgb_cmd_t;

  typedef struct packed {
    logic                coord_ok;
    logic [RADIUS_W-1:0] radius;
    logic                done;
  } sgb_status_t;

  function automatic logic [RADIUS_W-1:0] abs_off(input off_t k);
    logic [3:0] m;
    m = k[3] ? (4'd0 - k) : k;
    return m[RADIUS_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

endpackage

// File: hw/rtl/sgb_datapath.sv
// ----------------------------------------------------------------------------
// sgb_datapath: frame memory, configuration and blur arithmetic
// Holds the frame store, the register file, the horizontal and vertical
// multiply-accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
module sgb_datapath #(
  parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sgb_pkg::COORD_W-1:0]         in_col,
  input  logic [sgb_pkg::COORD_W-1:0]         in_row_index,
  input  logic [sgb_pkg::PIXEL_W-1:0]         in_pixel_in,
  input  logic                                cfg_we,
  input  logic [sgb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  sgb_pkg::sgb_cmd_t                   cmd,
  output sgb_pkg::sgb_status_t                status,
  output logic [sgb_pkg::PIXEL_W-1:0]         out_blurred_pixel,
  output logic                                out_out_of_range
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCAP   = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
  localparam int HCAP   = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
  localparam int CH_W   = sgb_pkg::CH_W;
  localparam int NUM_CH = sgb_pkg::NUM_CH;

  // configuration registers
  logic [sgb_pkg::DIM_W-1:0]    width_r, height_r;
  logic [sgb_pkg::RADIUS_W-1:0] radius_r;
  logic [sgb_pkg::WEIGHT_W-1:0] weight_r [sgb_pkg::NUM_WEIGHTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= sgb_pkg::WIDTH_RST;
      height_r    <= sgb_pkg::HEIGHT_RST;
      radius_r    <= sgb_pkg::RADIUS_RST;
      weight_r[0] <= sgb_pkg::W_CENTER_RST;
      weight_r[1] <= sgb_pkg::W_ONE_RST;
      weight_r[2] <= sgb_pkg::W_TWO_RST;
      weight_r[3] <= sgb_pkg::W_THREE_RST;
      weight_r[4] <= sgb_pkg::W_FOUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sgb_pkg::REG_WIDTH:    width_r     <= cfg_data[sgb_pkg::DIM_W-1:0];
        sgb_pkg::REG_HEIGHT:   height_r    <= cfg_data[sgb_pkg::DIM_W-1:0];
        sgb_pkg::REG_RADIUS:   radius_r    <= cfg_data[sgb_pkg::RADIUS_W-1:0];
        sgb_pkg::REG_W_CENTER: weight_r[0] <= cfg_data;
        sgb_pkg::REG_W_ONE:    weight_r[1] <= cfg_data;
        sgb_pkg::REG_W_TWO:    weight_r[2] <= cfg_data;
        sgb_pkg::REG_W_THREE:  weight_r[3] <= cfg_data;
        sgb_pkg::REG_W_FOUR:   weight_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective limits
  logic [sgb_pkg::DIM_W-1:0]    eff_w, eff_h;
  logic [sgb_pkg::RADIUS_W-1:0] eff_r;

  assign eff_w = ({25'd0, width_r} > 32'(WCAP)) ? sgb_pkg::DIM_W'(WCAP) : width_r;
  assign eff_h = ({25'd0, height_r} > 32'(HCAP)) ? sgb_pkg::DIM_W'(HCAP) : height_r;
  assign eff_r = (radius_r > sgb_pkg::RADIUS_W'(MAX_RADIUS)) ?
                 sgb_pkg::RADIUS_W'(MAX_RADIUS) : radius_r;

  // query coordinate
  logic [sgb_pkg::COORD_W-1:0] col_r, row_r;
  logic                        oor_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r <= in_col;
      row_r <= in_row_index;
      oor_r <= !status.coord_ok;
    end
  end

  // clamped read coordinate
  logic signed [8:0]           sx, sy, wmax, hmax;
  logic [sgb_pkg::COORD_W-1:0] cx, cy;

  always_comb begin
    sx   = $signed({3'b000, col_r}) + $signed({{5{cmd.kh[3]}}, cmd.kh});
    sy   = $signed({3'b000, row_r}) + $signed({{5{cmd.kv[3]}}, cmd.kv});
    wmax = $signed({2'b00, eff_w}) - 9'sd1;
    hmax = $signed({2'b00, eff_h}) - 9'sd1;
    if (sx < 9'sd0)     cx = '0;
    else if (sx > wmax) cx = wmax[sgb_pkg::COORD_W-1:0];
    else                cx = sx[sgb_pkg::COORD_W-1:0];
    if (sy < 9'sd0)     cy = '0;
    else if (sy > hmax) cy = hmax[sgb_pkg::COORD_W-1:0];
    else                cy = sy[sgb_pkg::COORD_W-1:0];
  end

  logic [ADDR_W-1:0] wr_addr, rd_addr, mem_addr;

  assign wr_addr  = ADDR_W'({26'd0, in_row_index} * MAX_WIDTH + {26'd0, in_col});
  assign rd_addr  = ADDR_W'({26'd0, cy} * MAX_WIDTH + {26'd0, cx});
  assign mem_addr = cmd.wr_en ? wr_addr : rd_addr;

  // single-port frame store
  logic [sgb_pkg::PIXEL_W-1:0] frame_mem [DEPTH];
  logic [sgb_pkg::PIXEL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) frame_mem[mem_addr] <= in_pixel_in;
    if (cmd.rd_en) rd_data_r <= frame_mem[mem_addr];
  end

  // stage 1: read data and tap weights
  logic                         s1_valid_r, s1_first_r, s1_last_h_r, s1_last_v_r;
  logic [sgb_pkg::WEIGHT_W-1:0] s1_wh_r, s1_wv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= cmd.rd_en;
    s1_first_r  <= cmd.first_h;
    s1_last_h_r <= cmd.last_h;
    s1_last_v_r <= cmd.last_v;
    s1_wh_r     <= weight_r[sgb_pkg::abs_off(cmd.kh)];
    s1_wv_r     <= weight_r[sgb_pkg::abs_off(cmd.kv)];
  end

  // stage 2: horizontal taps
  logic                         s2_valid_r, s2_first_r, s2_last_h_r, s2_last_v_r;
  logic [sgb_pkg::WEIGHT_W-1:0] s2_wv_r;
  logic [CH_W-1:0]              s2_tap_r [NUM_CH];
  logic [sgb_pkg::PROD_W-1:0]   hprod [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      hprod[c] = {{sgb_pkg::WEIGHT_W{1'b0}}, rd_data_r[c*CH_W +: CH_W]} *
                 {{CH_W{1'b0}}, s1_wh_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else        s2_valid_r <= s1_valid_r;
    s2_first_r  <= s1_first_r;
    s2_last_h_r <= s1_last_h_r;
    s2_last_v_r <= s1_last_v_r;
    s2_wv_r     <= s1_wv_r;
    for (int c = 0; c < NUM_CH; c++) begin
      s2_tap_r[c] <= hprod[c][sgb_pkg::TAP_SHIFT +: CH_W];
    end
  end

  // stage 3: horizontal accumulate
  logic                         s3_row_r, s3_last_v_r;
  logic [sgb_pkg::WEIGHT_W-1:0] s3_wv_r;
  logic [CH_W-1:0]              hacc_r [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) s3_row_r <= 1'b0;
    else        s3_row_r <= s2_valid_r && s2_last_h_r;
    s3_last_v_r <= s2_last_v_r;
    s3_wv_r     <= s2_wv_r;
    if (s2_valid_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        hacc_r[c] <= s2_first_r ? s2_tap_r[c] : sgb_pkg::sat_add(hacc_r[c], s2_tap_r[c]);
      end
    end
  end

  // stage 4: vertical taps on finished row sums
  logic                       s4_valid_r, s4_last_v_r;
  logic [CH_W-1:0]            vtap_r [NUM_CH];
  logic [sgb_pkg::PROD_W-1:0] vprod [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      vprod[c] = {{sgb_pkg::WEIGHT_W{1'b0}}, hacc_r[c]} * {{CH_W{1'b0}}, s3_wv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_valid_r <= 1'b0;
    else        s4_valid_r <= s3_row_r;
    s4_last_v_r <= s3_last_v_r;
    for (int c = 0; c < NUM_CH; c++) begin
      vtap_r[c] <= vprod[c][sgb_pkg::TAP_SHIFT +: CH_W];
    end
  end

  // stage 5: vertical accumulate
  logic            done_r;
  logic [CH_W-1:0] vacc_r [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= s4_valid_r && s4_last_v_r;
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd.capture)     vacc_r[c] <= '0;
      else if (s4_valid_r) vacc_r[c] <= sgb_pkg::sat_add(vacc_r[c], vtap_r[c]);
    end
  end

  // output register
  logic [sgb_pkg::PIXEL_W-1:0] out_pix_r;
  logic                        out_oor_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pix_r <= oor_r ? '0 : {vacc_r[3], vacc_r[2], vacc_r[1], vacc_r[0]};
      out_oor_r <= oor_r;
    end
  end

  assign out_blurred_pixel = out_pix_r;
  assign out_out_of_range  = out_oor_r;

  assign status.coord_ok = ({1'b0, in_col} < eff_w) && ({1'b0, in_row_index} < eff_h);
  assign status.radius   = eff_r;
  assign status.done     = done_r;

endmodule

// File: hw/rtl/sgb_ctrl.sv
// ----------------------------------------------------------------------------
// sgb_ctrl: transaction controller of the blur engine
// Accepts transactions, sequences the kernel window reads, waits for the
// pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module sgb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sgb_pkg::sgb_status_t status,
  output sgb_pkg::sgb_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  sgb_pkg::off_t       kh_r, kh_nxt, kv_r, kv_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;
  sgb_pkg::off_t       rpos, rneg;

  assign rpos     = {1'b0, status.radius};
  assign rneg     = 4'sd0 - rpos;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    kh_nxt        = kh_r;
    kv_nxt        = kv_r;
    cmd           = '0;
    cmd.kh        = kh_r;
    cmd.kv        = kv_r;
    cmd.first_h   = (kh_r == rneg);
    cmd.last_h    = (kh_r == rpos);
    cmd.last_v    = (kh_r == rpos) && (kv_r == rpos);
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == sgb_pkg::OP_QUERY) begin
            cmd.capture = 1'b1;
            kh_nxt      = rneg;
            kv_nxt      = rneg;
            state_nxt   = status.coord_ok ? ST_SCAN : ST_OUT;
          end else begin
            cmd.wr_en = status.coord_ok;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cmd.last_v) begin
          state_nxt = ST_WAIT;
        end else if (cmd.last_h) begin
          kh_nxt = rneg;
          kv_nxt = kv_r + 4'sd1;
        end else begin
          kh_nxt = kh_r + 4'sd1;
        end
      end
      ST_WAIT: begin
        if (status.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      kh_r        <= '0;
      kv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kh_r        <= kh_nxt;
      kv_r        <= kv_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |-> (state_r == ST_WAIT))
    else $error("pipeline finished outside of the wait state");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_en))
    else $error("frame write and read in the same cycle");

endmodule

// File: hw/rtl/separable_gaussian_blur_top.sv
// ----------------------------------------------------------------------------
// separable_gaussian_blur_top: frame-store Gaussian blur engine
// Stores ARGB pixels and answers blurred-pixel queries with clamped edges.
// ----------------------------------------------------------------------------
// An in-range query with effective radius r reads (2r+1)*(2r+1) stored
// pixels, one per cycle from the single-port frame memory, then waits for
// the multiply-accumulate pipeline to drain and loads the result. An
// out-of-range query reads no pixels. One transaction is in work at a time;
// a finished result waits in the output register while the next
// transaction is taken. The frame memory is not cleared after reset, and
// only written pixels may be read.
module separable_gaussian_blur_top #(
  parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [sgb_pkg::COORD_W-1:0]     in_col,
  input  logic [sgb_pkg::COORD_W-1:0]     in_row_index,
  input  logic [sgb_pkg::PIXEL_W-1:0]     in_pixel_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sgb_pkg::PIXEL_W-1:0]     out_blurred_pixel,
  output logic                            out_out_of_range,
  input  logic                            cfg_we,
  input  logic [sgb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sgb_pkg::sgb_cmd_t    cmd;
  sgb_pkg::sgb_status_t status;

  sgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sgb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_col            (in_col),
    .in_row_index      (in_row_index),
    .in_pixel_in       (in_pixel_in),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .status            (status),
    .out_blurred_pixel (out_blurred_pixel),
    .out_out_of_range  (out_out_of_range)
  );

endmodule
